@@ hdl/gsa_pkg.sv @@
package gsa_pkg;

  // Fixed field widths
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 10;
  localparam int GEN_W  = 16;
  localparam int ST_W   = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic init_wr;    // write one entry of the clearing pass
    logic load;       // capture the item, start memory reads
    logic pop;        // allocate: take top of stack, read its generation
    logic finish;     // write the result register
    logic fin_alloc;  // result comes from the allocate path
  } gsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic init_last;
    logic op_alloc;
    logic stack_empty;
  } gsa_sts_t;

endpackage

@@ hdl/gsa_in_if.sv @@
interface gsa_in_if
  import gsa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  slot_index;
  logic [GEN_W-1:0]  generation;

  modport source (output valid, output func, output slot_index, output generation,
                  input ready);
  modport sink   (input valid, input func, input slot_index, input generation,
                  output ready);
endinterface

@@ hdl/gsa_out_if.sv @@
interface gsa_out_if
  import gsa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] slot_index_res;
  logic [GEN_W-1:0] generation_res;
  logic             is_valid;

  modport source (output valid, output status, output slot_index_res,
                  output generation_res, output is_valid, input ready);
  modport sink   (input valid, input status, input slot_index_res,
                  input generation_res, input is_valid, output ready);
endinterface

@@ hdl/gsa_ram.sv @@
module gsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ hdl/gsa_dp.sv @@
module gsa_dp
  import gsa_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gsa_cmd_t          cmd,
  output gsa_sts_t          sts,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [GEN_W-1:0]  in_generation,
  output logic [ST_W-1:0]   out_status_r,
  output logic [IDX_W-1:0]  out_slot_index_r,
  output logic [GEN_W-1:0]  out_generation_r,
  output logic              out_is_valid_r
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [IW-1:0]     clr_r;
  logic [CW-1:0]     count_r;
  logic [FUNC_W-1:0] op_func_r;
  logic [IDX_W-1:0]  op_idx_r;
  logic [GEN_W-1:0]  op_gen_r;
  logic              op_oor_r;

  logic [IW-1:0]     op_idx_mem;
  logic [CW-1:0]     count_dec;
  logic              in_oor;
  logic              stack_full;
  logic              commit_free;

  logic              gen_we;
  logic [IW-1:0]     gen_waddr;
  logic [GEN_W-1:0]  gen_wdata;
  logic              gen_re;
  logic [IW-1:0]     gen_raddr;
  logic [GEN_W-1:0]  gen_q;
  logic [GEN_W-1:0]  gen_inc;

  logic              stk_we;
  logic [IW-1:0]     stk_waddr;
  logic [IW-1:0]     stk_wdata;
  logic [IW-1:0]     stk_q;

  logic [ST_W-1:0]   res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [GEN_W-1:0]  res_gen;
  logic              res_valid;

  assign op_idx_mem = IW'(op_idx_r);
  assign count_dec  = count_r - CW'(1);
  assign in_oor     = 32'(in_slot_index) >= SLOTS;
  assign stack_full = count_r == CW'(SLOTS);
  assign gen_inc    = gen_q + GEN_W'(1);

  assign commit_free = cmd.finish && !cmd.fin_alloc && (op_func_r == FUNC_FREE) &&
                       !op_oor_r && !stack_full;

  assign sts.init_last   = clr_r == IW'(SLOTS - 1);
  assign sts.op_alloc    = op_func_r == FUNC_ALLOC;
  assign sts.stack_empty = count_r == '0;

  // Generation memory: init pass writes 1, free writes the bumped value
  assign gen_we    = cmd.init_wr || commit_free;
  assign gen_waddr = cmd.init_wr ? clr_r : op_idx_mem;
  assign gen_wdata = cmd.init_wr ? GEN_W'(1) : gen_inc;
  assign gen_re    = cmd.load || cmd.pop;
  assign gen_raddr = cmd.pop ? stk_q : IW'(in_slot_index);

  gsa_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
    .clk     (clk),
    .we      (gen_we),
    .waddr   (gen_waddr),
    .wdata   (gen_wdata),
    .re      (gen_re),
    .raddr   (gen_raddr),
    .rdata_r (gen_q)
  );

  // Free stack: init pass writes descending indices, free pushes at count
  assign stk_we    = cmd.init_wr || commit_free;
  assign stk_waddr = cmd.init_wr ? clr_r : count_r[IW-1:0];
  assign stk_wdata = cmd.init_wr ? (IW'(SLOTS - 1) - clr_r) : op_idx_mem;

  gsa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stack_ram (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_waddr),
    .wdata   (stk_wdata),
    .re      (cmd.load),
    .raddr   (count_dec[IW-1:0]),
    .rdata_r (stk_q)
  );

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      count_r <= CW'(SLOTS);
    end else begin
      if (cmd.init_wr) begin
        clr_r <= clr_r + IW'(1);
      end
      if (cmd.pop) begin
        count_r <= count_dec;
      end else if (commit_free) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func_r <= in_func;
      op_idx_r  <= in_slot_index;
      op_gen_r  <= in_generation;
      op_oor_r  <= in_oor;
    end
  end

  // Result selection
  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_gen    = '0;
    res_valid  = 1'b0;
    if (cmd.fin_alloc) begin
      res_idx = IDX_W'(stk_q);
      res_gen = gen_q;
    end else begin
      case (op_func_r)
        FUNC_ALLOC: begin
          res_status = ST_EMPTY;
        end
        FUNC_FREE: begin
          res_idx = op_idx_r;
          if (op_oor_r) begin
            res_status = ST_RANGE;
          end else if (stack_full) begin
            res_status = ST_FULL;
            res_gen    = gen_q;
          end else begin
            res_gen = gen_inc;
          end
        end
        FUNC_CHECK: begin
          res_idx = op_idx_r;
          if (op_oor_r) begin
            res_status = ST_RANGE;
          end else begin
            res_gen   = gen_q;
            res_valid = gen_q == op_gen_r;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r     <= res_status;
      out_slot_index_r <= res_idx;
      out_generation_r <= res_gen;
      out_is_valid_r   <= res_valid;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("free count above capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_dec))
    else $error("allocate did not decrement count");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    commit_free |=> count_r == $past(count_r) + CW'(1))
    else $error("free did not increment count");
`endif

endmodule

@@ hdl/gsa_ctrl.sv @@
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  gsa_sts_t sts,
  output gsa_cmd_t cmd
);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_ALLOC = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op_alloc && !sts.stack_empty) begin
          cmd.pop   = 1'b1;
          state_nxt = S_ALLOC;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          cmd.fin_alloc = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken item");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.stack_empty)
    else $error("pop from empty stack");

  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EXEC) && !in_ready)
    else $error("accepted item not executed");
`endif

endmodule

@@ hdl/generational_slot_allocator.sv @@
// An accepted item is captured; free, check, the no-op code and an allocate from an empty
// stack then write the result register from EXEC, while any other allocate pops in EXEC and
// writes it from ALLOC, since the generation read waits on the stack read. in_ch.ready is
// low until the result is written, and that write waits while out_ch holds an untaken one.
// Reset: synchronous, active low; a clearing pass over every slot then fills the
// free stack and sets every generation to 1, with in_ch.ready held low.
module generational_slot_allocator
  import gsa_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input logic        clk,
  input logic        rst_n,
  gsa_in_if.sink     in_ch,
  gsa_out_if.source  out_ch
);

  gsa_cmd_t cmd;
  gsa_sts_t sts;

  // Sequencer
  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Memories, pointers and result register
  gsa_dp #(.SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_ch.func),
    .in_slot_index    (in_ch.slot_index),
    .in_generation    (in_ch.generation),
    .out_status_r     (out_ch.status),
    .out_slot_index_r (out_ch.slot_index_res),
    .out_generation_r (out_ch.generation_res),
    .out_is_valid_r   (out_ch.is_valid)
  );

endmodule
